// ===== hdl/dacd_pkg.sv =====
// Shared types, codes, step table and decode functions for the dual ADPCM channel decoder.
package dacd_pkg;

    localparam logic REQ_CONTROL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef enum logic [0:0] {
        CFG_FETCH_ENABLE = 1'b0,
        CFG_RATE_SHIFT   = 1'b1
    } cfg_index_t;

    localparam logic [5:0] StepIndexMax = 6'd48;
    localparam logic [3:0] DividerMax   = 4'd8;

    typedef logic signed [14:0] sample_t;

    typedef struct packed {
        sample_t     pred;
        logic [5:0]  idx;
        sample_t     pending;
        logic [3:0]  repeats;
        logic [1:0]  pos;
        logic [15:0] word;
        logic        wvalid;
    } chan_state_t;

    typedef struct packed {
        logic       adv;
        logic       tick;
        logic       run1;
        logic       run2;
        logic       clear;
        logic       interp;
        logic       hold;
        logic       fetch_en;
        logic [1:0] rate_shift;
    } chan_ctl_t;

    function automatic logic [10:0] step_size(input logic [5:0] idx);
        logic [10:0] s;
        case (idx)
            6'd0:  s = 11'd16;
            6'd1:  s = 11'd17;
            6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;
            6'd4:  s = 11'd23;
            6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;
            6'd7:  s = 11'd31;
            6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;
            6'd10: s = 11'd41;
            6'd11: s = 11'd45;
            6'd12: s = 11'd50;
            6'd13: s = 11'd55;
            6'd14: s = 11'd60;
            6'd15: s = 11'd66;
            6'd16: s = 11'd73;
            6'd17: s = 11'd80;
            6'd18: s = 11'd88;
            6'd19: s = 11'd97;
            6'd20: s = 11'd107;
            6'd21: s = 11'd118;
            6'd22: s = 11'd130;
            6'd23: s = 11'd143;
            6'd24: s = 11'd157;
            6'd25: s = 11'd173;
            6'd26: s = 11'd190;
            6'd27: s = 11'd209;
            6'd28: s = 11'd230;
            6'd29: s = 11'd253;
            6'd30: s = 11'd279;
            6'd31: s = 11'd307;
            6'd32: s = 11'd337;
            6'd33: s = 11'd371;
            6'd34: s = 11'd408;
            6'd35: s = 11'd449;
            6'd36: s = 11'd494;
            6'd37: s = 11'd544;
            6'd38: s = 11'd598;
            6'd39: s = 11'd658;
            6'd40: s = 11'd724;
            6'd41: s = 11'd796;
            6'd42: s = 11'd876;
            6'd43: s = 11'd963;
            6'd44: s = 11'd1060;
            6'd45: s = 11'd1166;
            6'd46: s = 11'd1282;
            6'd47: s = 11'd1411;
            default: s = 11'd1552;
        endcase
        return s;
    endfunction

    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        logic [2:0] m1;
        m1 = {1'b0, mag[1:0]} + 3'd1;
        return mag[2] ? $signed({1'b0, m1, 1'b0}) : -5'sd1;
    endfunction

    function automatic sample_t saturate_add(input sample_t a, input sample_t b);
        logic signed [15:0] sum;
        sum = {a[14], a} + {b[14], b};
        if (sum[15] != sum[14])
            return sum[15] ? 15'sh4000 : 15'sh3FFF;
        return sum[14:0];
    endfunction

    function automatic logic round_fetches(input chan_state_t s, input logic fe);
        return (s.wvalid | fe) && (s.pos == 2'd0);
    endfunction

    function automatic chan_state_t decode_round(
        input chan_state_t s,
        input logic [15:0] word_in,
        input logic        fe,
        input logic        hold,
        input logic        interp,
        input logic [1:0]  rs
    );
        chan_state_t       r;
        logic [15:0]       w;
        logic [3:0]        nib;
        logic [14:0]       mag;
        logic signed [4:0] mv;
        logic signed [6:0] nidx;
        logic [1:0]        npos;
        r = s;
        if (s.wvalid | fe) begin
            w = (s.pos == 2'd0) ? word_in : s.word;
            r.word = w;
            if (s.pos == 2'd0)
                r.wvalid = 1'b1;
            nib = w[{s.pos, 2'b00} +: 4];
            if (hold) begin
                r.pending = '0;
            end
            else begin
                mag = 15'(step_size(s.idx)) * 15'({1'b0, nib[2:0]} + 4'd1);
                if (interp)
                    mag = mag >> rs;
                r.pending = nib[3] ? sample_t'(-mag) : sample_t'(mag);
                mv = index_move(nib[2:0]);
                nidx = $signed({1'b0, s.idx}) + {{2{mv[4]}}, mv};
                if (nidx < 7'sd0)
                    r.idx = 6'd0;
                else if (nidx > $signed({1'b0, StepIndexMax}))
                    r.idx = StepIndexMax;
                else
                    r.idx = nidx[5:0];
            end
            r.repeats = interp ? (4'd1 << rs) : 4'd1;
            npos = s.pos + 2'd1;
            r.pos = npos;
            if (npos == 2'd0)
                r.wvalid = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== hdl/dacd_channel.sv =====
// One decoder channel: nibble fetch, step adaptation, delta spreading and predictor state.
module dacd_channel (
    input  logic               clk,
    input  logic               rst_n,
    input  dacd_pkg::chan_ctl_t ctl,
    input  logic [15:0]        data_in,
    output dacd_pkg::sample_t  pred_next,
    output logic               fetched
);
    import dacd_pkg::*;

    chan_state_t state_reg;
    chan_state_t state_next;
    chan_state_t r1;
    chan_state_t r2;
    chan_state_t acc;
    logic        f1;
    logic        f2;

    always_comb
    begin
        r1 = ctl.run1 ? decode_round(state_reg, data_in, ctl.fetch_en, ctl.hold,
                                     ctl.interp, ctl.rate_shift) : state_reg;
        f1 = ctl.run1 && round_fetches(state_reg, ctl.fetch_en);
        r2 = ctl.run2 ? decode_round(r1, data_in, ctl.fetch_en, ctl.hold,
                                     ctl.interp, ctl.rate_shift) : r1;
        f2 = ctl.run2 && round_fetches(r1, ctl.fetch_en);
        acc = r2;
        if (acc.repeats != 4'd0) begin
            acc.pred = saturate_add(acc.pred, acc.pending);
            acc.repeats = acc.repeats - 4'd1;
        end
        state_next = state_reg;
        fetched = 1'b0;
        if (ctl.tick) begin
            state_next = acc;
            fetched = f1 | f2;
        end
        else if (ctl.clear) begin
            state_next.pred = '0;
            state_next.idx = 6'd0;
        end
    end

    assign pred_next = state_next.pred;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (ctl.adv)
            state_reg <= state_next;
    end

    // The step index never leaves the table range.
    assert property (@(posedge clk) disable iff (!rst_n) state_reg.idx <= StepIndexMax)
        else $error("step index out of range");

    // A channel in the middle of a word always holds that word.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pos != 2'd0 |-> state_reg.wvalid)
        else $error("nibble position advanced without a latched word");

    // A control transaction never decodes.
    assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.tick |-> !fetched && !ctl.run1 && !ctl.run2)
        else $error("decode round outside a tick");

endmodule

// ===== hdl/dual_adpcm_channel_decoder.sv =====
// Top level of the two-channel 4-bit ADPCM decoder.
// An accepted transaction goes to the input register, and its result to the result register.
// Throughput: one transaction per cycle; the input register and the result register
// decouple the channels, so input stalls only while a result is held and stalled.
// Reset (rst_n, asynchronous, active low) clears configuration, control word, divider
// and all channel state; the first tick after reset may run two decode rounds.
module dual_adpcm_channel_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [15:0]          control_value,
    input  logic [15:0]          data_ch0,
    input  logic [15:0]          data_ch1,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dacd_pkg::sample_t    sample_ch0,
    output dacd_pkg::sample_t    sample_ch1,
    output logic                 fetched_ch0,
    output logic                 fetched_ch1,
    input  logic                 cfg_write,
    input  dacd_pkg::cfg_index_t cfg_index,
    input  logic [1:0]           cfg_data
);
    import dacd_pkg::*;

    logic        s1_valid_reg;
    logic        s1_type_reg;
    logic [15:0] s1_ctrl_reg;
    logic [15:0] s1_data0_reg;
    logic [15:0] s1_data1_reg;
    logic [15:0] ctrl_reg;
    logic [1:0]  fe_reg;
    logic [1:0]  rs_reg;
    logic [3:0]  div_reg;
    logic [3:0]  div_next;
    logic        out_valid_reg;
    sample_t     sample0_reg;
    sample_t     sample1_reg;
    logic        fetched0_reg;
    logic        fetched1_reg;
    logic        adv;
    logic        accept;
    logic        s1_tick;
    logic        run1;
    logic        run2;
    chan_ctl_t   ctl0;
    chan_ctl_t   ctl1;
    sample_t     pred0_next;
    sample_t     pred1_next;
    logic        fetch0;
    logic        fetch1;

    assign adv = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;
    assign s1_tick = (s1_type_reg == REQ_TICK);

    always_comb
    begin
        run1 = 1'b0;
        run2 = 1'b0;
        div_next = div_reg;
        if (s1_tick) begin
            if (div_reg == 4'd0) begin
                run1 = 1'b1;
                if (rs_reg == 2'd0) begin
                    run2 = 1'b1;
                    div_next = 4'd1;
                end
                else begin
                    div_next = (4'd1 << rs_reg) - 4'd1;
                end
            end
            else if (div_reg == 4'd1) begin
                run1 = 1'b1;
                div_next = 4'd1 << rs_reg;
            end
            else begin
                div_next = div_reg - 4'd1;
            end
        end
    end

    always_comb
    begin
        ctl0.adv = adv;
        ctl0.tick = s1_tick;
        ctl0.run1 = run1;
        ctl0.run2 = run2;
        ctl0.clear = !s1_tick && !ctrl_reg[4] && s1_ctrl_reg[4];
        ctl0.interp = ctrl_reg[2];
        ctl0.hold = ctrl_reg[4];
        ctl0.fetch_en = fe_reg[0];
        ctl0.rate_shift = rs_reg;
        ctl1.adv = adv;
        ctl1.tick = s1_tick;
        ctl1.run1 = run1;
        ctl1.run2 = run2;
        ctl1.clear = !s1_tick && !ctrl_reg[5] && s1_ctrl_reg[5];
        ctl1.interp = ctrl_reg[3];
        ctl1.hold = ctrl_reg[5];
        ctl1.fetch_en = fe_reg[1];
        ctl1.rate_shift = rs_reg;
    end

    dacd_channel u_ch0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl0),
        .data_in   (s1_data0_reg),
        .pred_next (pred0_next),
        .fetched   (fetch0)
    );

    dacd_channel u_ch1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl1),
        .data_in   (s1_data1_reg),
        .pred_next (pred1_next),
        .fetched   (fetch1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fe_reg <= 2'd0;
            rs_reg <= 2'd0;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                CFG_FETCH_ENABLE: fe_reg <= cfg_data;
                CFG_RATE_SHIFT:   rs_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg <= 16'd0;
            div_reg <= 4'd0;
        end
        else begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (adv)
                s1_valid_reg <= 1'b0;
            out_valid_reg <= adv || (out_valid_reg && out_stall);
            if (adv) begin
                div_reg <= div_next;
                if (!s1_tick)
                    ctrl_reg <= s1_ctrl_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_type_reg <= req_type;
            s1_ctrl_reg <= control_value;
            s1_data0_reg <= data_ch0;
            s1_data1_reg <= data_ch1;
        end
        if (adv) begin
            sample0_reg <= pred0_next;
            sample1_reg <= pred1_next;
            fetched0_reg <= fetch0;
            fetched1_reg <= fetch1;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample_ch0 = sample0_reg;
    assign sample_ch1 = sample1_reg;
    assign fetched_ch0 = fetched0_reg;
    assign fetched_ch1 = fetched1_reg;

    // A second decode round only happens on the first tick after reset at rate shift zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        run2 |-> run1 && div_reg == 4'd0 && rs_reg == 2'd0)
        else $error("double decode round outside the post-reset tick");

    // The divider never exceeds its largest reload value.
    assert property (@(posedge clk) disable iff (!rst_n) div_reg <= DividerMax)
        else $error("rate divider out of range");

    // A control transaction produces a result with no fetch flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && !s1_tick |=> out_valid_reg && !fetched0_reg && !fetched1_reg)
        else $error("fetch flagged on a control transaction");

    // Input is held back only while a result waits in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && s1_valid_reg && !adv)
        else $error("input stalled without a blocked result");

endmodule
